// File: hdl/sfba_pkg.sv
// Shared types and constants for the swap frame bitmap allocator.
// Used by sfba_scan, swap_frame_bitmap_allocator, sfba_checker and the testbench; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sfba_pkg;

    localparam int FRAMES  = 64;
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = $clog2(FRAMES + 1);
    localparam int FIU_W   = 7;
    localparam int WANT_W  = 7;
    localparam int FRAME_W = 6;

    localparam logic [FIU_W-1:0] FIU_RESET = FIU_W'(64);

    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_DECIDE,
        S_GRANT
    } state_t;

    typedef struct packed {
        logic clear;
        logic step;
        logic tally;
    } scan_ctl_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        logic             at_end;
        logic             bit_free;
    } scan_sts_t;

endpackage : sfba_pkg

`default_nettype wire

// File: hdl/sfba_scan.sv
// Shared scan unit: frame index counter, tally counter and end-of-range compare.
// Depends on sfba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfba_scan
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire sfba_pkg::scan_ctl_t        ctl,
    input  wire logic [sfba_pkg::FRAMES-1:0] map,
    input  wire logic [sfba_pkg::CNT_W-1:0] lim,
    output sfba_pkg::scan_sts_t             sts
);
    import sfba_pkg::*;

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb
    begin
        if (ctl.clear)
        begin
            idx_next = '0;
        end
        else if (ctl.step)
        begin
            idx_next = CNT_W'(idx_reg + 1'b1);
        end
        else
        begin
            idx_next = idx_reg;
        end

        if (ctl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctl.tally)
        begin
            cnt_next = CNT_W'(cnt_reg + 1'b1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    assign sts.idx      = idx_reg[IDX_W-1:0];
    assign sts.cnt      = cnt_reg;
    assign sts.at_end   = (idx_reg >= lim);
    assign sts.bit_free = ~map[idx_reg[IDX_W-1:0]];

endmodule : sfba_scan

`default_nettype wire

// File: hdl/swap_frame_bitmap_allocator.sv
// Free and empty requests are answered in the cycle after acceptance.
// Allocate: a counting pass up to min(frames_in_use, 64) over the shared scan unit, a decide
// state, then a grant pass up to the last grant that stalls while the result is held.
// One request at a time; s_tready is high only between requests, while the result is free.
// Reset (rst_n, async, active low): every frame free, frames_in_use = 64, outputs idle.
// Top level; depends on sfba_pkg and sfba_scan.
`timescale 1ns / 1ps
`default_nettype none

module swap_frame_bitmap_allocator
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [6:0] request_count, [12:7] free_frame, rest zero
    input  wire logic        s_tuser,   // [0] cmd
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [5:0] frame_number, rest zero
    output logic [1:0]       m_tuser,   // [1:0] status
    output logic             m_tlast,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import sfba_pkg::*;

    state_t state_reg;
    state_t state_next;

    logic [FRAMES-1:0]  map_reg;
    logic [FRAMES-1:0]  map_next;
    logic [FIU_W-1:0]   fiu_reg;
    logic [WANT_W-1:0]  want_reg;
    logic [WANT_W-1:0]  want_next;

    logic               out_valid_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [1:0]         out_status_reg;
    logic               out_last_reg;

    logic               out_free;
    logic               accept;
    logic               out_load;
    logic [FRAME_W-1:0] out_frame;
    logic [1:0]         out_status;
    logic               out_last;
    logic               map_set;
    logic               map_clr;
    logic               grant_done;
    logic               short;

    logic [WANT_W-1:0]  in_count;
    logic [FRAME_W-1:0] in_free;
    logic [CNT_W-1:0]   lim;

    scan_ctl_t scan_ctl;
    scan_sts_t scan_sts;

    assign in_count = s_tdata[6:0];
    assign in_free  = s_tdata[12:7];

    // Scan limit saturates at the frame count.
    assign lim = ({1'b0, fiu_reg} > (FIU_W + 1)'(FRAMES)) ? CNT_W'(FRAMES) : CNT_W'(fiu_reg);

    assign out_free   = !out_valid_reg || m_tready;
    assign short      = (WANT_W'(scan_sts.cnt) < want_reg);
    assign grant_done = (WANT_W'(scan_sts.cnt + 1'b1) == want_reg);

    sfba_scan u_scan
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .map   (map_reg),
        .lim   (lim),
        .sts   (scan_sts)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && s_tuser == CMD_ALLOC && in_count != '0)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (scan_sts.at_end)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!short)
                begin
                    state_next = S_GRANT;
                end
                else if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_GRANT:
            begin
                if (out_free && scan_sts.bit_free && grant_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        s_tready   = 1'b0;
        scan_ctl   = '0;
        out_load   = 1'b0;
        out_frame  = '0;
        out_status = ST_GRANTED;
        out_last   = 1'b0;
        map_set    = 1'b0;
        map_clr    = 1'b0;
        want_next  = want_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = out_free;
                if (accept)
                begin
                    if (s_tuser == CMD_FREE)
                    begin
                        out_load   = 1'b1;
                        out_status = ST_FREED;
                        out_last   = 1'b1;
                        map_clr    = ({1'b0, in_free} < (FRAME_W + 1)'(FRAMES));
                    end
                    else if (in_count == '0)
                    begin
                        out_load   = 1'b1;
                        out_status = ST_EMPTY;
                        out_last   = 1'b1;
                    end
                    else
                    begin
                        scan_ctl.clear = 1'b1;
                        want_next      = in_count;
                    end
                end
            end
            S_COUNT:
            begin
                // Count free frames below the limit, one per cycle.
                if (!scan_sts.at_end)
                begin
                    scan_ctl.step  = 1'b1;
                    scan_ctl.tally = scan_sts.bit_free;
                end
            end
            S_DECIDE:
            begin
                if (short)
                begin
                    out_load   = out_free;
                    out_status = ST_SHORT;
                    out_last   = 1'b1;
                end
                else
                begin
                    // Restart the scan; the tally now counts grants.
                    scan_ctl.clear = 1'b1;
                end
            end
            S_GRANT:
            begin
                if (out_free)
                begin
                    scan_ctl.step = 1'b1;
                    if (scan_sts.bit_free)
                    begin
                        scan_ctl.tally = 1'b1;
                        out_load       = 1'b1;
                        out_frame      = FRAME_W'(scan_sts.idx);
                        out_status     = ST_GRANTED;
                        out_last       = grant_done;
                        map_set        = 1'b1;
                    end
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    always_comb
    begin
        map_next = map_reg;
        if (map_set)
        begin
            map_next[scan_sts.idx] = 1'b1;
        end
        if (map_clr)
        begin
            map_next[in_free[IDX_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            map_reg       <= '0;
            fiu_reg       <= FIU_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            if (psel && penable && pwrite && pready && paddr == ADDR_FRAMES_IN_USE)
            begin
                fiu_reg <= pwdata[FIU_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        want_reg <= want_next;
        if (out_load)
        begin
            out_frame_reg  <= out_frame;
            out_status_reg <= out_status;
            out_last_reg   <= out_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - FRAME_W){1'b0}}, out_frame_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? {{(32 - FIU_W){1'b0}}, fiu_reg} : '0;

    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> state_reg == S_IDLE)
        else $error("input accepted outside idle");

    a_grant_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GRANT |-> !scan_sts.at_end)
        else $error("grant scan ran past the limit");

    a_granted_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_GRANTED) |-> map_reg[m_tdata[IDX_W-1:0]])
        else $error("granted frame not marked used");

    a_short_keeps_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && short) |=> $stable(map_reg))
        else $error("failed allocate changed the bitmap");

endmodule : swap_frame_bitmap_allocator

`default_nettype wire

// File: sim/sfba_checker.sv
// Checker for the swap frame bitmap allocator: watches the request, result and APB channels,
// predicts the result stream, and compares it field by field. Depends on sfba_pkg.
`timescale 1ns / 1ps

module sfba_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [6:0] request_count, [12:7] free_frame, rest zero
    input  logic        s_tuser,    // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,    // [5:0] frame_number, rest zero
    input  logic [1:0]  m_tuser,    // [1:0] status
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          mismatches,
    output int          results_outstanding
);
    import sfba_pkg::*;

    typedef struct {
        logic [7:0] frame;
        logic [1:0] status;
        logic       last;
    } alloc_answer_t;

    logic [FRAMES-1:0] frame_map;
    logic [FIU_W-1:0]  frames_in_use;
    alloc_answer_t     answers_due[$];

    initial mismatches = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t ns] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic queue_answer(input logic [5:0] frame, input logic [1:0] status,
                                input logic last);
        alloc_answer_t a;
        a.frame  = {2'b00, frame};
        a.status = status;
        a.last   = last;
        answers_due.push_back(a);
    endtask

    // First-fit over frames below the scan limit; all-or-nothing grant.
    task automatic serve_request(input logic cmd, input logic [WANT_W-1:0] want,
                                 input logic [FRAME_W-1:0] victim);
        int scan_end;
        int available;
        int granted;
        if (cmd == CMD_FREE)
        begin
            frame_map[victim] = 1'b0;
            queue_answer('0, ST_FREED, 1'b1);
        end
        else if (want == 0)
        begin
            queue_answer('0, ST_EMPTY, 1'b1);
        end
        else
        begin
            scan_end  = (frames_in_use > FRAMES) ? FRAMES : int'(frames_in_use);
            available = 0;
            for (int i = 0; i < scan_end; i++)
                if (!frame_map[i])
                    available++;
            if (available < want)
            begin
                queue_answer('0, ST_SHORT, 1'b1);
            end
            else
            begin
                granted = 0;
                for (int i = 0; i < scan_end && granted < want; i++)
                begin
                    if (!frame_map[i])
                    begin
                        frame_map[i] = 1'b1;
                        granted++;
                        queue_answer(6'(i), ST_GRANTED, granted == want);
                    end
                end
            end
        end
    endtask

    task automatic check_answer();
        alloc_answer_t a;
        if (answers_due.size() == 0)
        begin
            report_mismatch($sformatf("result with nothing pending: frame %0d status %0d last %0d",
                                      m_tdata, m_tuser, m_tlast));
        end
        else
        begin
            a = answers_due.pop_front();
            if (m_tdata !== a.frame)
                report_mismatch($sformatf("frame_number expected %0d, got %0d", a.frame, m_tdata));
            if (m_tuser !== a.status)
                report_mismatch($sformatf("status expected %0d, got %0d", a.status, m_tuser));
            if (m_tlast !== a.last)
                report_mismatch($sformatf("last expected %0d, got %0d", a.last, m_tlast));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_map     = '0;
            frames_in_use = FIU_RESET;
            answers_due.delete();
            results_outstanding <= 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ADDR_FRAMES_IN_USE)
            begin
                if (pwrite)
                    frames_in_use = pwdata[FIU_W-1:0];
                else if (prdata !== 32'(frames_in_use))
                    report_mismatch($sformatf("frames_in_use read expected %0d, got %0d",
                                              frames_in_use, prdata));
            end
            if (m_tvalid && m_tready)
                check_answer();
            if (s_tvalid && s_tready)
                serve_request(s_tuser, s_tdata[6:0], s_tdata[12:7]);
            results_outstanding <= answers_due.size();
        end
    end

endmodule

// File: sim/tb_swap_frame_bitmap_allocator.sv
// Testbench top for swap_frame_bitmap_allocator: drives requests, result back-pressure and
// APB writes and reads; sfba_checker predicts and compares. Depends on sfba_pkg, sfba_checker and the DUT.
`timescale 1ns / 1ps

module tb_swap_frame_bitmap_allocator;
    import sfba_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [6:0] request_count, [12:7] free_frame, rest zero
    logic        s_tuser;   // [0] cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [5:0] frame_number, rest zero
    logic [1:0]  m_tuser;   // [1:0] status
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          results_outstanding;
    int          cycles;
    bit          bursts_on;
    logic [5:0]  held_frames[$];

    swap_frame_bitmap_allocator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sfba_checker u_checker
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .m_tlast             (m_tlast),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .mismatches          (mismatches),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Remember granted frames so most frees hit frames actually in use.
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready && m_tuser == ST_GRANTED)
            held_frames.push_back(m_tdata[5:0]);
    end

    // Result side back-pressure.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (bursts_on && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input logic cmd, input logic [6:0] want,
                                input logic [5:0] victim);
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, victim, want};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Junk goes in the field the command does not use.
    task automatic alloc(input int want);
        send_request(CMD_ALLOC, 7'(want), 6'($urandom));
    endtask

    task automatic release_frame(input int frame);
        send_request(CMD_FREE, 7'($urandom), 6'(frame));
    endtask

    // Hold the request side until every pending result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_FRAMES_IN_USE;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frames_in_use(input int frames);
        drain();
        apb_access(1'b1, {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, 7'(frames)});
        apb_access(1'b0, 32'd0);
    endtask

    task automatic random_requests(input int n);
        int pick;
        int sel;
        int idx;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    alloc($urandom_range(1, 4));
                else if (sel < 17)
                    alloc($urandom_range(5, 16));
                else if (sel == 17)
                    alloc(0);
                else if (sel == 18)
                    alloc($urandom_range(17, 64));
                else
                    alloc($urandom_range(65, 127));
            end
            else if (held_frames.size() != 0 && $urandom_range(0, 3) != 0)
            begin
                idx = $urandom_range(0, held_frames.size() - 1);
                release_frame(held_frames[idx]);
                held_frames.delete(idx);
            end
            else
            begin
                release_frame($urandom_range(0, 63));
            end
        end
    endtask

    initial
    begin
        cycles    = 0;
        bursts_on = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, at the reset limit of 64 frames.
        alloc(0);
        alloc(1);
        alloc(3);
        release_frame(2);
        release_frame(2);       // already free
        alloc(2);               // refill the hole, then next free frame
        alloc(127);
        alloc(65);
        release_frame(63);
        alloc(64);              // too few free
        alloc(58);
        alloc(2);
        alloc(1);               // takes the top frame
        alloc(1);               // map full
        release_frame(0);
        alloc(1);

        set_frames_in_use(0);
        alloc(1);
        random_requests(14);

        set_frames_in_use(1);
        release_frame(40);      // cleared even though beyond the scan limit
        alloc(1);
        random_requests(18);

        // Limit saturates at FRAMES.
        set_frames_in_use(127);
        random_requests(100);

        set_frames_in_use($urandom_range(2, 63));
        random_requests(100);

        set_frames_in_use($urandom_range(2, 63));
        random_requests(100);

        bursts_on = 1'b0;
        set_frames_in_use(64);
        for (int f = 0; f < FRAMES; f++)
            release_frame(f);
        held_frames.delete();
        alloc(64);              // whole map in one request
        release_frame(0);
        release_frame(63);
        random_requests(58);

        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0 && results_outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
